### rtl/assert_macros.svh
// Assertion macros used by the RTL of the touch sample filter.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

### rtl/tsfc_pkg.sv
// Shared constants and types of the touch sample filter and calibration block.
// No dependencies; compile first after the assertion header.
package tsfc_pkg;

  localparam int SAMPLE_BITS_DEF = 13;
  localparam int BYTE_W          = 8;
  localparam int SAMPLE_SHIFT    = 3;
  localparam int CAL_W           = 13;
  localparam int RES_W           = 12;
  localparam int ORIENT_W        = 3;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 5;
  localparam int REG_IDX_W       = 3;

  // Register indexes (byte address is 4 times the index)
  localparam logic [REG_IDX_W-1:0] REG_X_MIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_MAX  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Y_MIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_MAX  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_H_RES  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_V_RES  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ORIENT = 3'd6;

  // Register reset values
  localparam logic [CAL_W-1:0]    X_MIN_RST  = 13'd200;
  localparam logic [CAL_W-1:0]    X_MAX_RST  = 13'd3800;
  localparam logic [CAL_W-1:0]    Y_MIN_RST  = 13'd200;
  localparam logic [CAL_W-1:0]    Y_MAX_RST  = 13'd3800;
  localparam logic [RES_W-1:0]    H_RES_RST  = 12'd480;
  localparam logic [RES_W-1:0]    V_RES_RST  = 12'd320;
  localparam logic [ORIENT_W-1:0] ORIENT_RST = 3'd0;

  // Orientation bits
  localparam int ORIENT_SWAP  = 0;
  localparam int ORIENT_INV_X = 1;
  localparam int ORIENT_INV_Y = 2;

  // Calibration settings of one axis
  typedef struct packed {
    logic [CAL_W-1:0] minimum;
    logic [CAL_W-1:0] maximum;
    logic [RES_W-1:0] resolution;
    logic             invert;
  } axis_cfg_t;

endpackage

### rtl/tsfc_if.sv
// Stream interfaces of the touch sample filter: raw sample pairs in, positions out.
// Depends on tsfc_pkg for field widths.
interface tsfc_in_if;
  import tsfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] x_high_byte;
  logic [BYTE_W-1:0] x_low_byte;
  logic [BYTE_W-1:0] y_high_byte;
  logic [BYTE_W-1:0] y_low_byte;
  logic              first_sample;
  logic              last_sample;

  modport source (
    output valid, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
           first_sample, last_sample,
    input  ready
  );
  modport sink (
    input  valid, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
           first_sample, last_sample,
    output ready
  );
endinterface

interface tsfc_out_if;
  import tsfc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] x_position;
  logic [RES_W-1:0] y_position;

  modport source (output valid, x_position, y_position, input ready);
  modport sink (input valid, x_position, y_position, output ready);
endinterface

### rtl/tsfc_axis_cal.sv
// Bit-serial calibration of one axis: shift-add multiply, then restoring divide.
// Depends on tsfc_pkg for widths and the axis_cfg_t settings type.
module tsfc_axis_cal #(
  parameter int SAMPLE_BITS = tsfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [SAMPLE_BITS-1:0]     value,
  input  tsfc_pkg::axis_cfg_t        cfg,
  output logic                       done,
  output logic [tsfc_pkg::RES_W-1:0] result
);
  import tsfc_pkg::*;

  localparam int OW    = (SAMPLE_BITS > CAL_W) ? SAMPLE_BITS : CAL_W;
  localparam int PW    = OW + RES_W;
  localparam int REM_W = CAL_W + 1;
  localparam int CNT_W = $clog2(RES_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RES_W - 1);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_PREP = 3'd2;
  localparam logic [2:0] U_DIV  = 3'd3;
  localparam logic [2:0] U_FIN  = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [OW-1:0]    off;
  logic [CAL_W-1:0] dvs;
  logic             degen;
  logic [RES_W-1:0] res;
  logic             inv;
  logic [RES_W-1:0] mul_sh;
  logic [PW-1:0]    acc;
  logic [REM_W-1:0] rem;
  logic [RES_W-1:0] low_sh;
  logic [RES_W-1:0] quo;

  logic [OW-1:0]    v_ext;
  logic [OW-1:0]    lo_ext;
  logic [OW-1:0]    off_in;
  logic [PW-1:0]    addend;
  logic [PW-1:0]    acc_next;
  logic [REM_W-1:0] trial;
  logic             fits;
  logic [REM_W-1:0] rem_next;
  logic             sat;
  logic [RES_W-1:0] scaled;
  logic [RES_W-1:0] result_next;

  // Offset above the minimum, clamped at zero
  assign v_ext  = OW'(value);
  assign lo_ext = OW'(cfg.minimum);
  assign off_in = (v_ext > lo_ext) ? (v_ext - lo_ext) : '0;

  // One multiplier bit per cycle, resolution MSB first
  assign addend   = mul_sh[RES_W-1] ? PW'(off) : '0;
  assign acc_next = {acc[PW-2:0], 1'b0} + addend;

  // One quotient bit per cycle
  assign trial    = {rem[CAL_W-1:0], low_sh[RES_W-1]};
  assign fits     = (trial >= REM_W'(dvs));
  assign rem_next = fits ? (trial - REM_W'(dvs)) : trial;

  // Offset at or beyond the span saturates; an empty span gives the resolution, before inversion
  assign sat         = degen | (off >= OW'(dvs));
  assign scaled      = sat ? res : quo;
  assign result_next = inv ? (res - scaled) : scaled;

  // Sequence multiply, divide and finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            off    <= off_in;
            dvs    <= cfg.maximum - cfg.minimum;
            degen  <= (cfg.maximum <= cfg.minimum);
            res    <= cfg.resolution;
            inv    <= cfg.invert;
            mul_sh <= cfg.resolution;
            acc    <= '0;
            cnt    <= '0;
            state  <= U_MUL;
          end
        end
        U_MUL: begin
          acc    <= acc_next;
          mul_sh <= {mul_sh[RES_W-2:0], 1'b0};
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= U_PREP;
          end
        end
        U_PREP: begin
          // Upper product bits stay below the divisor unless saturated
          rem    <= REM_W'(acc >> RES_W);
          low_sh <= acc[RES_W-1:0];
          cnt    <= '0;
          state  <= U_DIV;
        end
        U_DIV: begin
          rem    <= rem_next;
          low_sh <= {low_sh[RES_W-2:0], 1'b0};
          quo    <= {quo[RES_W-2:0], fits};
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= U_FIN;
          end
        end
        U_FIN: begin
          result <= result_next;
          done   <= 1'b1;
          state  <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/touch_sample_filter_calibrate_core.sv
// Top level of the touch sample filter: sample averaging, APB registers, control.
// Depends on tsfc_pkg, tsfc_if, tsfc_axis_cal and assert_macros.svh.
//
//   channel     kind          role
//   sample_in   valid/ready   raw X/Y conversion bytes with run markers
//   coord_out   valid/ready   calibrated X/Y pixel position
//   apb         APB write/rd  calibration registers, 4-byte spacing
//
// An item without last_sample leaves the input ready for the next transfer.
// An item with last_sample holds the input off through launch, calculation and
// the wait for the output register to take the result: two bit-serial passes of 12
// steps each (multiply, divide) in the per-axis units, plus control.
// rst (synchronous) restores register defaults and clears the running values.
// A result waiting on coord_out does not block new input; a second result waits
// for the first one's transfer.
`include "assert_macros.svh"

module touch_sample_filter_calibrate_core #(
  parameter int SAMPLE_BITS = tsfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  tsfc_in_if.sink                         sample_in,
  tsfc_out_if.source                      coord_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsfc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tsfc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tsfc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tsfc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  logic [1:0]             state;
  logic [CAL_W-1:0]       x_min;
  logic [CAL_W-1:0]       x_max;
  logic [CAL_W-1:0]       y_min;
  logic [CAL_W-1:0]       y_max;
  logic [RES_W-1:0]       h_res;
  logic [RES_W-1:0]       v_res;
  logic [ORIENT_W-1:0]    orient;
  logic [SAMPLE_BITS-1:0] running_x;
  logic [SAMPLE_BITS-1:0] running_y;
  logic                   out_valid;
  logic [RES_W-1:0]       x_position;
  logic [RES_W-1:0]       y_position;

  logic                   in_xfer;
  logic                   out_xfer;
  logic                   out_load;
  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic [SAMPLE_BITS-1:0] sx;
  logic [SAMPLE_BITS-1:0] sy;
  logic [SAMPLE_BITS:0]   sum_x;
  logic [SAMPLE_BITS:0]   sum_y;
  logic [SAMPLE_BITS-1:0] value_a;
  logic [SAMPLE_BITS-1:0] value_b;
  axis_cfg_t              cfg_x;
  axis_cfg_t              cfg_y;
  logic                   cal_start;
  logic                   x_done;
  logic                   y_done;
  logic [RES_W-1:0]       x_result;
  logic [RES_W-1:0]       y_result;

  assign in_xfer         = sample_in.valid && sample_in.ready;
  assign out_xfer        = coord_out.valid && coord_out.ready;
  assign sample_in.ready = (state == S_IDLE);
  assign cal_start       = (state == S_START);

  // Load the output register when it is empty or drains in this cycle
  assign out_load = (state == S_HOLD) && (!out_valid || coord_out.ready);

  // APB register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min  <= X_MIN_RST;
      x_max  <= X_MAX_RST;
      y_min  <= Y_MIN_RST;
      y_max  <= Y_MAX_RST;
      h_res  <= H_RES_RST;
      v_res  <= V_RES_RST;
      orient <= ORIENT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_X_MIN:  x_min  <= pwdata[CAL_W-1:0];
        REG_X_MAX:  x_max  <= pwdata[CAL_W-1:0];
        REG_Y_MIN:  y_min  <= pwdata[CAL_W-1:0];
        REG_Y_MAX:  y_max  <= pwdata[CAL_W-1:0];
        REG_H_RES:  h_res  <= pwdata[RES_W-1:0];
        REG_V_RES:  v_res  <= pwdata[RES_W-1:0];
        REG_ORIENT: orient <= pwdata[ORIENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_MIN:  prdata = APB_DATA_W'(x_min);
      REG_X_MAX:  prdata = APB_DATA_W'(x_max);
      REG_Y_MIN:  prdata = APB_DATA_W'(y_min);
      REG_Y_MAX:  prdata = APB_DATA_W'(y_max);
      REG_H_RES:  prdata = APB_DATA_W'(h_res);
      REG_V_RES:  prdata = APB_DATA_W'(v_res);
      REG_ORIENT: prdata = APB_DATA_W'(orient);
      default:    prdata = '0;
    endcase
  end

  // Assemble samples and average with the running values
  assign sx    = SAMPLE_BITS'({sample_in.x_high_byte, sample_in.x_low_byte} >> SAMPLE_SHIFT);
  assign sy    = SAMPLE_BITS'({sample_in.y_high_byte, sample_in.y_low_byte} >> SAMPLE_SHIFT);
  assign sum_x = {1'b0, running_x} + {1'b0, sx};
  assign sum_y = {1'b0, running_y} + {1'b0, sy};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_x <= '0;
      running_y <= '0;
    end else if (in_xfer) begin
      if (sample_in.first_sample) begin
        running_x <= sx;
        running_y <= sy;
      end else if ((sx != '0) && (sy != '0)) begin
        running_x <= sum_x[SAMPLE_BITS:1];
        running_y <= sum_y[SAMPLE_BITS:1];
      end
    end
  end

  // Swap axes and hand each value its calibration settings
  assign value_a = orient[ORIENT_SWAP] ? running_y : running_x;
  assign value_b = orient[ORIENT_SWAP] ? running_x : running_y;

  assign cfg_x = '{minimum: x_min, maximum: x_max, resolution: h_res,
                   invert: orient[ORIENT_INV_X]};
  assign cfg_y = '{minimum: y_min, maximum: y_max, resolution: v_res,
                   invert: orient[ORIENT_INV_Y]};

  tsfc_axis_cal #(.SAMPLE_BITS(SAMPLE_BITS)) u_cal_x (
    .clk    (clk),
    .rst    (rst),
    .start  (cal_start),
    .value  (value_a),
    .cfg    (cfg_x),
    .done   (x_done),
    .result (x_result)
  );

  tsfc_axis_cal #(.SAMPLE_BITS(SAMPLE_BITS)) u_cal_y (
    .clk    (clk),
    .rst    (rst),
    .start  (cal_start),
    .value  (value_b),
    .cfg    (cfg_y),
    .done   (y_done),
    .result (y_result)
  );

  // Control: accept, launch calibration, wait, hand off to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer && sample_in.last_sample) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (x_done) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_load) begin
            x_position <= x_result;
            y_position <= y_result;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign coord_out.valid      = out_valid;
  assign coord_out.x_position = x_position;
  assign coord_out.y_position = y_position;

  // Checks on control sequencing
  `ASSERT_IMP(a_done_in_calc, clk, rst, x_done, state == S_CALC)
  `ASSERT_IMP(a_units_lockstep, clk, rst, 1'b1, x_done == y_done)
  `ASSERT_NEXT(a_last_starts_cal, clk, rst, in_xfer && sample_in.last_sample, state == S_START)
  `ASSERT_NEXT(a_out_drains, clk, rst, out_xfer && (state != S_HOLD), !out_valid)

endmodule
